// File: hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define AWSU_ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the default clock and reset of this block.
`define AWSU_ASSERT(name, prop, msg) \
  `AWSU_ASSERT_CLK(name, clk_i, rst_ni, prop, msg)

`endif

// File: hw/rtl/awsu_pkg.sv
// Types and codes shared by the anagram window search unit.
package awsu_pkg;

  // Input command codes.
  localparam logic [1:0] CmdClear   = 2'd0;
  localparam logic [1:0] CmdPattern = 2'd1;
  localparam logic [1:0] CmdText    = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] symbol;
    logic       last;
  } item_t;

  typedef struct packed {
    logic match_here;
    logic found_so_far;
    logic pattern_overflow;
    logic end_of_text;
  } result_t;

  // Work handed from the front part to the back part.
  typedef enum logic [2:0] {
    UopClear,
    UopPattern,
    UopSkip,
    UopAdd,
    UopSwap
  } uop_kind_e;

  typedef struct packed {
    uop_kind_e kind;
    logic      always_match;
    logic      full_window;
    logic      overflow;
    logic      last;
  } uop_t;

endpackage

// File: hw/rtl/awsu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module awsu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the old contents when the same address is written.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/awsu_fifo.sv
// Small register-based queue with first-word-visible read.
module awsu_fifo #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, wptr_d;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// File: hw/rtl/awsu_front.sv
// Front part: accepts items, tracks pattern and window, keeps the text ring.
module awsu_front #(
  parameter int unsigned MAX_PATTERN = 32,
  parameter int unsigned SYMBOL_BITS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  awsu_pkg::item_t        item_i,
  output logic                   full_o,
  output logic                   uop_valid_o,
  input  logic                   uop_ready_i,
  output awsu_pkg::uop_t         uop_o,
  output logic [SYMBOL_BITS-1:0] uop_sym_a_o,
  output logic [SYMBOL_BITS-1:0] uop_sym_b_o
);

  localparam int unsigned LenW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned PtrW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned IdxW = LenW + 1;

  logic [LenW-1:0]        plen_q, plen_d;
  logic [LenW-1:0]        wfill_q, wfill_d;
  logic [PtrW-1:0]        ptr_q, ptr_d;
  logic                   ovf_q, ovf_d;
  logic                   s1_valid_q, s1_valid_d;
  awsu_pkg::uop_t         s1_uop_q, s1_uop_d;
  logic [SYMBOL_BITS-1:0] s1_sym_q, s1_sym_d;
  logic                   s1_rem_q, s1_rem_d;

  logic                   take;
  logic [SYMBOL_BITS-1:0] sym_in;
  logic [IdxW-1:0]        ptr_w, plen_w, idx_w;
  logic                   ring_we, ring_re;
  logic [SYMBOL_BITS-1:0] ring_rdata;

  assign full_o = s1_valid_q && !uop_ready_i;
  assign take   = push_i && !full_o;
  assign sym_in = SYMBOL_BITS'(item_i.symbol);

  // Slot of the byte that leaves the window.
  assign ptr_w  = IdxW'(ptr_q);
  assign plen_w = IdxW'(plen_q);
  assign idx_w  = (ptr_w >= plen_w) ? ptr_w - plen_w
                                    : ptr_w + IdxW'(MAX_PATTERN) - plen_w;

  always_comb begin
    plen_d     = plen_q;
    wfill_d    = wfill_q;
    ptr_d      = ptr_q;
    ovf_d      = ovf_q;
    s1_valid_d = s1_valid_q && !uop_ready_i;
    s1_uop_d   = s1_uop_q;
    s1_sym_d   = s1_sym_q;
    s1_rem_d   = s1_rem_q;
    ring_we    = 1'b0;
    ring_re    = 1'b0;
    if (take) begin
      s1_uop_d = '{kind: awsu_pkg::UopSkip, always_match: 1'b0, full_window: 1'b0,
                   overflow: ovf_q, last: item_i.last};
      s1_sym_d = sym_in;
      s1_rem_d = 1'b0;
      unique case (item_i.command)
        awsu_pkg::CmdClear: begin
          plen_d          = '0;
          wfill_d         = '0;
          ptr_d           = '0;
          ovf_d           = 1'b0;
          s1_uop_d.kind   = awsu_pkg::UopClear;
          s1_valid_d      = 1'b1;
        end
        awsu_pkg::CmdPattern: begin
          // Drop pattern bytes once text sits in the window.
          if (wfill_q == '0) begin
            if (plen_q >= LenW'(MAX_PATTERN)) begin
              ovf_d = 1'b1;
            end else begin
              plen_d        = plen_q + 1'b1;
              s1_uop_d.kind = awsu_pkg::UopPattern;
              s1_valid_d    = 1'b1;
            end
          end
        end
        awsu_pkg::CmdText: begin
          s1_valid_d = 1'b1;
          if (plen_q == '0) begin
            s1_uop_d.always_match = 1'b1;
          end else begin
            ring_we = 1'b1;
            ptr_d   = (ptr_w == IdxW'(MAX_PATTERN - 1)) ? '0 : ptr_q + 1'b1;
            if (wfill_q >= plen_q) begin
              s1_rem_d = 1'b1;
              ring_re  = 1'b1;
            end else begin
              wfill_d = wfill_q + 1'b1;
            end
            s1_uop_d.kind        = awsu_pkg::UopAdd;
            s1_uop_d.full_window = (wfill_d == plen_q);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q     <= '0;
      wfill_q    <= '0;
      ptr_q      <= '0;
      ovf_q      <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      plen_q     <= plen_d;
      wfill_q    <= wfill_d;
      ptr_q      <= ptr_d;
      ovf_q      <= ovf_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_uop_q <= s1_uop_d;
    s1_sym_q <= s1_sym_d;
    s1_rem_q <= s1_rem_d;
  end

  awsu_ram #(
    .WIDTH(SYMBOL_BITS),
    .DEPTH(MAX_PATTERN)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ring_we),
    .waddr_i(ptr_q),
    .wdata_i(sym_in),
    .re_i   (ring_re),
    .raddr_i(idx_w[PtrW-1:0]),
    .rdata_o(ring_rdata)
  );

  // A leaving byte equal to the entering one leaves the table unchanged.
  always_comb begin
    uop_o = s1_uop_q;
    if (s1_rem_q) begin
      uop_o.kind = (ring_rdata == s1_sym_q) ? awsu_pkg::UopSkip : awsu_pkg::UopSwap;
    end
  end

  assign uop_valid_o = s1_valid_q;
  assign uop_sym_a_o = ring_rdata;
  assign uop_sym_b_o = s1_sym_q;

endmodule

// File: hw/rtl/awsu_back.sv
// Back part: updates the count table and nonzero count, forms results.
module awsu_back #(
  parameter int unsigned MAX_PATTERN = 32,
  parameter int unsigned SYMBOL_BITS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   uop_valid_i,
  output logic                   uop_pop_o,
  input  awsu_pkg::uop_t         uop_i,
  input  logic [SYMBOL_BITS-1:0] sym_a_i,
  input  logic [SYMBOL_BITS-1:0] sym_b_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output awsu_pkg::result_t      res_o
);

  localparam int unsigned NumSym = 2 ** SYMBOL_BITS;
  localparam int unsigned CntW   = $clog2(MAX_PATTERN + 1) + 1;
  localparam int unsigned NzW    = SYMBOL_BITS + 1;

  logic                   b_valid_q, b_valid_d;
  awsu_pkg::uop_t         b_uop_q, b_uop_d;
  logic [SYMBOL_BITS-1:0] b_sym_a_q, b_sym_a_d;
  logic [SYMBOL_BITS-1:0] b_sym_b_q, b_sym_b_d;
  logic                   b_phase_q, b_phase_d;
  logic                   byp_q, byp_d;
  logic [CntW-1:0]        byp_data_q, byp_data_d;
  logic                   hit_q, hit_d;
  logic [NumSym-1:0]      vld_q, vld_d;
  logic [NzW-1:0]         nz_q, nz_d, nz_next;
  logic                   found_q, found_d;

  logic                   is_clear, is_swap1, is_swap2, dec, upd, produce, fire;
  logic                   load, stay, next_valid, match;
  logic [SYMBOL_BITS-1:0] cur_addr, next_addr;
  logic [CntW-1:0]        rdata, old_val, new_val;

  assign is_clear = (b_uop_q.kind == awsu_pkg::UopClear);
  assign is_swap1 = (b_uop_q.kind == awsu_pkg::UopSwap) && !b_phase_q;
  assign is_swap2 = (b_uop_q.kind == awsu_pkg::UopSwap) && b_phase_q;
  assign dec      = (b_uop_q.kind == awsu_pkg::UopPattern) || is_swap1;
  assign upd      = dec || (b_uop_q.kind == awsu_pkg::UopAdd) || is_swap2;
  assign produce  = (b_uop_q.kind == awsu_pkg::UopSkip) ||
                    (b_uop_q.kind == awsu_pkg::UopAdd) || is_swap2;
  assign fire     = b_valid_q && (!produce || res_ready_i);

  assign cur_addr = is_swap1 ? b_sym_a_q : b_sym_b_q;
  assign old_val  = byp_q ? byp_data_q : (hit_q ? rdata : '0);
  assign new_val  = dec ? old_val - 1'b1 : old_val + 1'b1;

  always_comb begin
    nz_next = nz_q;
    if (upd) begin
      if (old_val == '0) begin
        nz_next = nz_q + 1'b1;
      end else if (new_val == '0) begin
        nz_next = nz_q - 1'b1;
      end
    end
  end

  assign match = b_uop_q.always_match || (b_uop_q.full_window && (nz_next == '0));

  assign res_valid_o = b_valid_q && produce;
  assign res_o = '{match_here: match, found_so_far: found_q || match,
                   pattern_overflow: b_uop_q.overflow, end_of_text: b_uop_q.last};

  // A swap keeps its slot for the add half; otherwise take the queue head.
  assign load       = !b_valid_q || fire;
  assign stay       = b_valid_q && is_swap1;
  assign next_valid = stay || uop_valid_i;
  assign uop_pop_o  = load && !stay && uop_valid_i;
  assign next_addr  = stay ? b_sym_b_q
                           : ((uop_i.kind == awsu_pkg::UopSwap) ? sym_a_i : sym_b_i);

  always_comb begin
    b_valid_d  = b_valid_q;
    b_uop_d    = b_uop_q;
    b_sym_a_d  = b_sym_a_q;
    b_sym_b_d  = b_sym_b_q;
    b_phase_d  = b_phase_q;
    byp_d      = byp_q;
    byp_data_d = byp_data_q;
    hit_d      = hit_q;
    vld_d      = vld_q;
    nz_d       = nz_q;
    found_d    = found_q;
    if (fire) begin
      if (is_clear) begin
        vld_d   = '0;
        nz_d    = '0;
        found_d = 1'b0;
      end else begin
        if (upd) begin
          vld_d[cur_addr] = 1'b1;
        end
        nz_d = nz_next;
        if (produce) begin
          found_d = found_q || match;
        end
      end
    end
    if (load) begin
      b_valid_d = next_valid;
      if (stay) begin
        b_phase_d = 1'b1;
      end else begin
        b_uop_d   = uop_i;
        b_sym_a_d = sym_a_i;
        b_sym_b_d = sym_b_i;
        b_phase_d = 1'b0;
      end
      // Forward what the RAM read misses: a write this edge or a clear.
      byp_d      = (fire && is_clear) || (fire && upd && (cur_addr == next_addr));
      byp_data_d = is_clear ? '0 : new_val;
      hit_d      = vld_q[next_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      b_phase_q <= 1'b0;
      byp_q     <= 1'b0;
      hit_q     <= 1'b0;
      vld_q     <= '0;
      nz_q      <= '0;
      found_q   <= 1'b0;
    end else begin
      b_valid_q <= b_valid_d;
      b_phase_q <= b_phase_d;
      byp_q     <= byp_d;
      hit_q     <= hit_d;
      vld_q     <= vld_d;
      nz_q      <= nz_d;
      found_q   <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_uop_q    <= b_uop_d;
    b_sym_a_q  <= b_sym_a_d;
    b_sym_b_q  <= b_sym_b_d;
    byp_data_q <= byp_data_d;
  end

  awsu_ram #(
    .WIDTH(CntW),
    .DEPTH(NumSym)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (fire && upd),
    .waddr_i(cur_addr),
    .wdata_i(new_val),
    .re_i   (load && next_valid),
    .raddr_i(next_addr),
    .rdata_o(rdata)
  );

endmodule

// File: hw/rtl/anagram_window_search_unit.sv
// Top level of the anagram window search unit.
// Streams pattern bytes then text bytes and flags every window of pattern
// length that is a permutation of the pattern. A clear item resets all state
// (the count table uses per-entry valid bits, so there is no clearing pass).
// The input takes one item per cycle while the queue to the back part has
// room. A text byte whose window is already full and whose entering and
// leaving symbols differ needs two updates of the count table, which has one
// write port, so the back part handles it as a decrement half and then an
// add half. A long run of such bytes therefore fills the queue to the back
// part and holds the input. A two-entry queue between front and back absorbs
// short bursts. A text byte passes the front stage register, the queue to the
// back part and the back-part register before its result reaches the output
// queue.
`include "assert_macros.svh"

module anagram_window_search_unit #(
  parameter int unsigned MAX_PATTERN = 32,
  parameter int unsigned SYMBOL_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  awsu_pkg::item_t   item_i,
  output logic              empty,
  input  logic              pop,
  output awsu_pkg::result_t result_o
);

  localparam int unsigned UopW = $bits(awsu_pkg::uop_t);
  localparam int unsigned MidW = UopW + 2 * SYMBOL_BITS;
  localparam int unsigned ResW = $bits(awsu_pkg::result_t);

  logic                   mid_push, mid_full, mid_pop, mid_empty;
  awsu_pkg::uop_t         f_uop, b_uop;
  logic [SYMBOL_BITS-1:0] f_sym_a, f_sym_b, b_sym_a, b_sym_b;
  logic [MidW-1:0]        mid_wdata, mid_rdata;
  logic                   res_push, res_full;
  awsu_pkg::result_t      res_data;
  logic [ResW-1:0]        res_rdata;

  awsu_front #(
    .MAX_PATTERN(MAX_PATTERN),
    .SYMBOL_BITS(SYMBOL_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .item_i     (item_i),
    .full_o     (full),
    .uop_valid_o(mid_push),
    .uop_ready_i(!mid_full),
    .uop_o      (f_uop),
    .uop_sym_a_o(f_sym_a),
    .uop_sym_b_o(f_sym_b)
  );

  assign mid_wdata = {f_uop, f_sym_a, f_sym_b};

  awsu_fifo #(
    .WIDTH(MidW),
    .DEPTH(2)
  ) u_mid_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (mid_push),
    .wdata_i(mid_wdata),
    .full_o (mid_full),
    .pop_i  (mid_pop),
    .rdata_o(mid_rdata),
    .empty_o(mid_empty)
  );

  assign b_uop   = awsu_pkg::uop_t'(mid_rdata[MidW-1 -: UopW]);
  assign b_sym_a = mid_rdata[2*SYMBOL_BITS-1 -: SYMBOL_BITS];
  assign b_sym_b = mid_rdata[SYMBOL_BITS-1:0];

  awsu_back #(
    .MAX_PATTERN(MAX_PATTERN),
    .SYMBOL_BITS(SYMBOL_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .uop_valid_i(!mid_empty),
    .uop_pop_o  (mid_pop),
    .uop_i      (b_uop),
    .sym_a_i    (b_sym_a),
    .sym_b_i    (b_sym_b),
    .res_valid_o(res_push),
    .res_ready_i(!res_full),
    .res_o      (res_data)
  );

  awsu_fifo #(
    .WIDTH(ResW),
    .DEPTH(2)
  ) u_res_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res_data),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(res_rdata),
    .empty_o(empty)
  );

  assign result_o = awsu_pkg::result_t'(res_rdata);

  `AWSU_ASSERT(MidPushRoom_A, mid_push |-> !mid_full || full, "front pushed into a full queue")
  `AWSU_ASSERT(MidPopData_A, mid_pop |-> !mid_empty, "back popped an empty queue")
  `AWSU_ASSERT(FullAfterAccept_A, $rose(full) |-> $past(push && !full),
               "full rose without an accepted item")

endmodule
